[design/zoll_pkg.sv]
// Shared constants, codes and control types for the z-order layer list.
package zoll_pkg;

    localparam int ID_COUNT = 64;
    localparam int ID_W = 6;
    localparam int DECL_W = 8;
    localparam int DELTA_W = 8;
    localparam int OUT_LAYER_W = 6;
    localparam int OUT_STATUS_W = 2;
    localparam int OUT_COUNT_W = 7;
    localparam int DEFAULT_MAX_SPRITES = 64;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_MOVE   = 1'b1
    } cmd_t;

    typedef enum logic [OUT_STATUS_W-1:0]
    {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_ALREADY = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE   = 2'd0,
        S_LOOK   = 2'd1,
        S_CALC   = 2'd2,
        S_COMMIT = 2'd3
    } state_t;

    typedef struct packed
    {
        logic capture;
        logic lookup;
        logic calc;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic out_free;
    } dp_status_t;

endpackage

[design/zoll_if.sv]
// Request and result channel interfaces of the z-order layer list.
interface zoll_req_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [zoll_pkg::ID_W-1:0]          sprite_id;
    logic [zoll_pkg::DECL_W-1:0]        declared_layer;
    logic signed [zoll_pkg::DELTA_W-1:0] delta;

    modport source
    (
        output valid,
        output command,
        output sprite_id,
        output declared_layer,
        output delta,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  command,
        input  sprite_id,
        input  declared_layer,
        input  delta,
        output ready
    );
endinterface

interface zoll_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [zoll_pkg::OUT_LAYER_W-1:0]  layer;
    logic [zoll_pkg::OUT_STATUS_W-1:0] status;
    logic [zoll_pkg::OUT_COUNT_W-1:0]  sprite_count;

    modport source
    (
        output valid,
        output layer,
        output status,
        output sprite_count,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  layer,
        input  status,
        input  sprite_count,
        output ready
    );
endinterface

[design/zoll_ctrl.sv]
// Controller state machine that sequences one request through lookup, clamp and commit.
module zoll_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  zoll_pkg::dp_status_t   status,
    output zoll_pkg::ctrl_cmd_t    ctrl
);

    zoll_pkg::state_t state_reg;
    zoll_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zoll_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            zoll_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = zoll_pkg::S_LOOK;
                end
            end
            zoll_pkg::S_LOOK:
            begin
                state_next = zoll_pkg::S_CALC;
            end
            zoll_pkg::S_CALC:
            begin
                state_next = zoll_pkg::S_COMMIT;
            end
            zoll_pkg::S_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = zoll_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = zoll_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.lookup  = 1'b0;
        ctrl.calc    = 1'b0;
        ctrl.commit  = 1'b0;
        case (state_reg)
            zoll_pkg::S_IDLE:
            begin
                req_ready    = 1'b1;
                ctrl.capture = req_valid;
            end
            zoll_pkg::S_LOOK:
            begin
                ctrl.lookup = 1'b1;
            end
            zoll_pkg::S_CALC:
            begin
                ctrl.calc = 1'b1;
            end
            zoll_pkg::S_COMMIT:
            begin
                ctrl.commit = status.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

[design/zoll_datapath.sv]
// Datapath with per-sprite layer cells, managed flags, clamp arithmetic and the result register.
module zoll_datapath
#(
    parameter int MAX_SPRITES = zoll_pkg::DEFAULT_MAX_SPRITES
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  zoll_pkg::ctrl_cmd_t                  ctrl,
    output zoll_pkg::dp_status_t                 status,
    input  logic                                 command,
    input  logic [zoll_pkg::ID_W-1:0]            sprite_id,
    input  logic [zoll_pkg::DECL_W-1:0]          declared_layer,
    input  logic signed [zoll_pkg::DELTA_W-1:0]  delta,
    input  logic                                 rsp_ready,
    output logic                                 rsp_valid,
    output logic [zoll_pkg::OUT_LAYER_W-1:0]     rsp_layer,
    output logic [zoll_pkg::OUT_STATUS_W-1:0]    rsp_status,
    output logic [zoll_pkg::OUT_COUNT_W-1:0]     rsp_sprite_count
);

    localparam int LAYER_W = $clog2(MAX_SPRITES);
    localparam int COUNT_W = $clog2(MAX_SPRITES + 1);
    localparam int WIDE_W = COUNT_W + zoll_pkg::DECL_W + 1;
    localparam int ID_COUNT = zoll_pkg::ID_COUNT;
    localparam int ID_W = zoll_pkg::ID_W;
    localparam int DECL_W = zoll_pkg::DECL_W;
    localparam int OUT_LAYER_W = zoll_pkg::OUT_LAYER_W;
    localparam int OUT_COUNT_W = zoll_pkg::OUT_COUNT_W;

    zoll_pkg::cmd_t              cmd_reg;
    logic [ID_W-1:0]             id_reg;
    logic [DECL_W-1:0]           decl_reg;
    logic signed [zoll_pkg::DELTA_W-1:0] delta_reg;

    logic                        hit_reg;
    logic [LAYER_W-1:0]          old_reg;

    zoll_pkg::status_t           stat_reg;
    zoll_pkg::status_t           stat_next;
    logic [LAYER_W-1:0]          tgt_reg;
    logic [LAYER_W-1:0]          tgt_next;

    logic [COUNT_W-1:0]          count_reg;
    logic [COUNT_W-1:0]          count_next;
    logic [ID_COUNT-1:0]         flags_reg;
    logic [ID_COUNT-1:0]         flags_next;
    logic [LAYER_W-1:0]          cells_reg [ID_COUNT];
    logic [LAYER_W-1:0]          cells_next [ID_COUNT];

    logic                        out_valid_reg;
    logic [OUT_LAYER_W-1:0]      out_layer_reg;
    logic [zoll_pkg::OUT_STATUS_W-1:0] out_status_reg;
    logic [OUT_COUNT_W-1:0]      out_count_reg;

    logic [DECL_W-1:0]           decl_m1;
    logic signed [WIDE_W-1:0]    count_s;
    logic signed [WIDE_W-1:0]    old_s;
    logic signed [WIDE_W-1:0]    delta_s;
    logic signed [WIDE_W-1:0]    decl_s;
    logic signed [WIDE_W-1:0]    sum_s;
    logic signed [WIDE_W-1:0]    lim_s;
    logic signed [WIDE_W-1:0]    ins_s;
    logic signed [WIDE_W-1:0]    mov_s;
    logic                        full;
    logic                        ins_do;
    logic                        mov_do;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= zoll_pkg::cmd_t'(command);
            id_reg    <= sprite_id;
            decl_reg  <= declared_layer;
            delta_reg <= delta;
        end
        if (ctrl.lookup)
        begin
            hit_reg <= flags_reg[id_reg];
            old_reg <= cells_reg[id_reg];
        end
        if (ctrl.calc)
        begin
            stat_reg <= stat_next;
            tgt_reg  <= tgt_next;
        end
        if (ctrl.commit)
        begin
            out_layer_reg  <= OUT_LAYER_W'(tgt_reg);
            out_status_reg <= stat_reg;
            out_count_reg  <= OUT_COUNT_W'(count_next);
        end
        cells_reg <= cells_next;
    end

    // Clamp of the insert position and of the move target.
    always_comb
    begin
        decl_m1 = (decl_reg == '0) ? '0 : decl_reg - 1'b1;
        count_s = $signed(WIDE_W'(count_reg));
        old_s   = $signed(WIDE_W'(old_reg));
        delta_s = WIDE_W'(delta_reg);
        decl_s  = $signed(WIDE_W'(decl_m1));
        sum_s   = old_s + delta_s;
        lim_s   = count_s - WIDE_W'(1);
        ins_s   = (decl_s > count_s) ? count_s : decl_s;
        if (sum_s < 0)
        begin
            mov_s = '0;
        end
        else if (sum_s > lim_s)
        begin
            mov_s = lim_s;
        end
        else
        begin
            mov_s = sum_s;
        end
        full = (count_reg >= COUNT_W'(MAX_SPRITES));

        if (cmd_reg == zoll_pkg::CMD_INSERT)
        begin
            if (hit_reg)
            begin
                stat_next = zoll_pkg::ST_ALREADY;
                tgt_next  = old_reg;
            end
            else if (full)
            begin
                stat_next = zoll_pkg::ST_FULL;
                tgt_next  = '0;
            end
            else
            begin
                stat_next = zoll_pkg::ST_OK;
                tgt_next  = LAYER_W'(ins_s);
            end
        end
        else
        begin
            if (!hit_reg || count_reg == '0)
            begin
                stat_next = zoll_pkg::ST_UNKNOWN;
                tgt_next  = '0;
            end
            else
            begin
                stat_next = zoll_pkg::ST_OK;
                tgt_next  = LAYER_W'(mov_s);
            end
        end
    end

    // All layer cells renumber in parallel against the new and, on a move, the old position.
    always_comb
    begin
        ins_do = ctrl.commit && cmd_reg == zoll_pkg::CMD_INSERT && stat_reg == zoll_pkg::ST_OK;
        mov_do = ctrl.commit && cmd_reg == zoll_pkg::CMD_MOVE && stat_reg == zoll_pkg::ST_OK;
        count_next = ins_do ? count_reg + 1'b1 : count_reg;
        flags_next = flags_reg;
        if (ins_do)
        begin
            flags_next[id_reg] = 1'b1;
        end
        for (int j = 0; j < ID_COUNT; j++)
        begin
            cells_next[j] = cells_reg[j];
            if (ins_do || mov_do)
            begin
                if (ID_W'(j) == id_reg)
                begin
                    cells_next[j] = tgt_reg;
                end
                else if (ins_do)
                begin
                    if (cells_reg[j] >= tgt_reg)
                    begin
                        cells_next[j] = cells_reg[j] + 1'b1;
                    end
                end
                else if (tgt_reg < old_reg)
                begin
                    if (cells_reg[j] >= tgt_reg && cells_reg[j] < old_reg)
                    begin
                        cells_next[j] = cells_reg[j] + 1'b1;
                    end
                end
                else if (tgt_reg > old_reg)
                begin
                    if (cells_reg[j] > old_reg && cells_reg[j] <= tgt_reg)
                    begin
                        cells_next[j] = cells_reg[j] - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            flags_reg <= flags_next;
            if (ctrl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid        = out_valid_reg;
    assign rsp_layer        = out_layer_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_sprite_count = out_count_reg;

endmodule

[design/z_order_layer_list.sv]
// Top level of the z-order layer list: controller, datapath and channel hookup.
//
// The block keeps the back-to-front layer of every managed sprite id and answers each
// request (insert at a declared layer, or move by a signed delta) with exactly one
// result holding the sprite's resulting layer, a status code and the sprite count.
// After the request is accepted, the result is produced in three steps: the first
// reads the sprite's managed flag and layer cell, the second does the clamp
// arithmetic, and the third commits, in which all 64 per-sprite layer cells renumber
// themselves in parallel. Ready is low during those steps. Requests are taken one at a
// time; a new request is accepted while the previous result is still waiting, and the
// commit step waits as long as an earlier result has not been taken. There is no
// clearing pass after reset.
module z_order_layer_list
#(
    parameter int MAX_SPRITES = zoll_pkg::DEFAULT_MAX_SPRITES
)
(
    input logic          clk,
    input logic          rst_n,
    zoll_req_if.sink     req,
    zoll_rsp_if.source   rsp
);

    zoll_pkg::ctrl_cmd_t  ctrl;
    zoll_pkg::dp_status_t status;

    zoll_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    zoll_datapath
    #(
        .MAX_SPRITES (MAX_SPRITES)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .status           (status),
        .command          (req.command),
        .sprite_id        (req.sprite_id),
        .declared_layer   (req.declared_layer),
        .delta            (req.delta),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_layer        (rsp.layer),
        .rsp_status       (rsp.status),
        .rsp_sprite_count (rsp.sprite_count)
    );

endmodule

[dv/zorder_checker.sv]
// Checker that predicts each z-order result from the accepted requests and compares it.
module zorder_checker
#(
    parameter int MAX_SPRITES = zoll_pkg::DEFAULT_MAX_SPRITES
)
(
    input  logic clk,
    input  logic rst_n,
    zoll_req_if  req,
    zoll_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding,
    output int   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_COUNT = zoll_pkg::ID_COUNT;
    localparam int ID_W = zoll_pkg::ID_W;
    localparam int DECL_W = zoll_pkg::DECL_W;
    localparam int DELTA_W = zoll_pkg::DELTA_W;
    localparam int OUT_LAYER_W = zoll_pkg::OUT_LAYER_W;
    localparam int OUT_COUNT_W = zoll_pkg::OUT_COUNT_W;

    typedef struct
    {
        logic [OUT_LAYER_W-1:0] layer;
        zoll_pkg::status_t      status;
        logic [OUT_COUNT_W-1:0] sprite_count;
    } answer_t;

    logic [ID_W-1:0] slot_id [MAX_SPRITES];
    int unsigned     rank_of [ID_COUNT];
    bit              known [ID_COUNT];
    int unsigned     population;
    answer_t         pending_answers [$];
    int              fault_count;
    int              checked_count;

    function automatic void enqueue_answer(answer_t a);
        pending_answers.insert(pending_answers.size(), a);
    endfunction

    function automatic void renumber_slots(int unsigned lo, int unsigned hi);
        for (int unsigned k = lo; k <= hi && k < population; k++)
        begin
            rank_of[slot_id[k]] = k;
        end
    endfunction

    function automatic answer_t reorder_sprites(zoll_pkg::cmd_t cmd, logic [ID_W-1:0] id,
                                                logic [DECL_W-1:0] decl,
                                                logic signed [DELTA_W-1:0] dlt);
        answer_t     ans;
        int unsigned pos;
        int unsigned old;
        int          target;
        ans.status = zoll_pkg::ST_OK;
        pos = 0;
        if (cmd == zoll_pkg::CMD_INSERT)
        begin
            if (known[id])
            begin
                ans.status = zoll_pkg::ST_ALREADY;
                pos = rank_of[id];
            end
            else if (population >= MAX_SPRITES)
            begin
                ans.status = zoll_pkg::ST_FULL;
            end
            else
            begin
                pos = (decl == 0) ? 0 : decl - 1;
                if (pos > population)
                begin
                    pos = population;
                end
                for (int unsigned k = population; k > pos; k--)
                begin
                    slot_id[k] = slot_id[k-1];
                end
                slot_id[pos] = id;
                population++;
                known[id] = 1'b1;
                renumber_slots(pos, population - 1);
            end
        end
        else
        begin
            if (!known[id] || population == 0)
            begin
                ans.status = zoll_pkg::ST_UNKNOWN;
            end
            else
            begin
                old = rank_of[id];
                target = int'(old) + int'(dlt);
                if (target < 0)
                begin
                    target = 0;
                end
                if (target > int'(population) - 1)
                begin
                    target = int'(population) - 1;
                end
                pos = target;
                if (old >= population)
                begin
                    old = population - 1;
                end
                if (pos < old)
                begin
                    for (int unsigned k = old; k > pos; k--)
                    begin
                        slot_id[k] = slot_id[k-1];
                    end
                    slot_id[pos] = id;
                    renumber_slots(pos, old);
                end
                else if (pos > old)
                begin
                    for (int unsigned k = old; k < pos; k++)
                    begin
                        slot_id[k] = slot_id[k+1];
                    end
                    slot_id[pos] = id;
                    renumber_slots(old, pos);
                end
            end
        end
        ans.layer = pos[OUT_LAYER_W-1:0];
        ans.sprite_count = population[OUT_COUNT_W-1:0];
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            population = 0;
            foreach (known[i])
            begin
                known[i] = 1'b0;
            end
            pending_answers.delete();
            fault_count = 0;
            checked_count = 0;
            mismatches <= 0;
            outstanding <= 0;
            checked <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.layer = rsp.layer;
                got.status = zoll_pkg::status_t'(rsp.status);
                got.sprite_count = rsp.sprite_count;
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: result with none awaited: layer %0d status %0d count %0d",
                             $time, got.layer, got.status, got.sprite_count);
                    fault_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    checked_count++;
                    if (got.layer !== want.layer)
                    begin
                        $display("%0t: layer expected %0d, got %0d",
                                 $time, want.layer, got.layer);
                        fault_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                        fault_count++;
                    end
                    if (got.sprite_count !== want.sprite_count)
                    begin
                        $display("%0t: sprite_count expected %0d, got %0d",
                                 $time, want.sprite_count, got.sprite_count);
                        fault_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                enqueue_answer(reorder_sprites(zoll_pkg::cmd_t'(req.command), req.sprite_id,
                                               req.declared_layer, req.delta));
            end
            mismatches <= fault_count;
            outstanding <= pending_answers.size();
            checked <= checked_count;
        end
    end

endmodule

[dv/tb_z_order_layer_list.sv]
// Testbench top for the z-order layer list: clock, reset, request stimulus and verdict.
module tb_z_order_layer_list;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD = 20;
    localparam int RANDOM_REQUESTS = 750;
    localparam int CALM_TAIL = 100;
    localparam int QUIET_LIMIT = 2000;
    localparam int ID_COUNT = zoll_pkg::ID_COUNT;
    localparam int ID_W = zoll_pkg::ID_W;
    localparam int DECL_W = zoll_pkg::DECL_W;
    localparam int DELTA_W = zoll_pkg::DELTA_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    zoll_req_if req_ch();
    zoll_rsp_if rsp_ch();

    int mismatches;
    int outstanding;
    int checked;
    bit gaps_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    bit placed [ID_COUNT];
    int filled = 0;
    int inserts_sent = 0;
    int moves_sent = 0;

    z_order_layer_list #(.MAX_SPRITES(zoll_pkg::DEFAULT_MAX_SPRITES)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    zorder_checker #(.MAX_SPRITES(zoll_pkg::DEFAULT_MAX_SPRITES)) order_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic issue_request(zoll_pkg::cmd_t c, logic [ID_W-1:0] id,
                                 logic [DECL_W-1:0] decl, logic signed [DELTA_W-1:0] d);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= c;
        req_ch.sprite_id <= id;
        req_ch.declared_layer <= decl;
        req_ch.delta <= d;
        do @(posedge clk); while (!req_ch.ready);
        if (c == zoll_pkg::CMD_INSERT)
        begin
            inserts_sent++;
            if (!placed[id])
            begin
                placed[id] = 1'b1;
                filled++;
            end
        end
        else
        begin
            moves_sent++;
        end
    endtask

    initial
    begin : stimulus
        int                        r;
        logic [ID_W-1:0]           id;
        logic [DECL_W-1:0]         decl;
        logic signed [DELTA_W-1:0] d;
        req_ch.valid <= 1'b0;
        req_ch.command <= zoll_pkg::CMD_INSERT;
        req_ch.sprite_id <= '0;
        req_ch.declared_layer <= '0;
        req_ch.delta <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(zoll_pkg::CMD_MOVE, 5, 0, 3);
        issue_request(zoll_pkg::CMD_INSERT, 10, 0, 0);
        issue_request(zoll_pkg::CMD_INSERT, 20, 255, 0);
        issue_request(zoll_pkg::CMD_INSERT, 30, 1, 0);
        issue_request(zoll_pkg::CMD_INSERT, 40, 2, 0);
        issue_request(zoll_pkg::CMD_INSERT, 10, 5, 0);
        issue_request(zoll_pkg::CMD_INSERT, 63, 3, 127);
        issue_request(zoll_pkg::CMD_MOVE, 30, 0, 127);
        issue_request(zoll_pkg::CMD_MOVE, 30, 0, -128);
        issue_request(zoll_pkg::CMD_MOVE, 40, 0, 0);
        issue_request(zoll_pkg::CMD_MOVE, 63, 255, 1);
        issue_request(zoll_pkg::CMD_MOVE, 63, 0, -1);
        issue_request(zoll_pkg::CMD_MOVE, 0, 0, -1);
        issue_request(zoll_pkg::CMD_INSERT, 0, 128, -128);
        issue_request(zoll_pkg::CMD_MOVE, 0, 0, 5);
        issue_request(zoll_pkg::CMD_MOVE, 20, 0, -2);
        issue_request(zoll_pkg::CMD_MOVE, 10, 0, 2);
        issue_request(zoll_pkg::CMD_INSERT, 21, 4, 0);
        issue_request(zoll_pkg::CMD_MOVE, 42, 170, 85);
        issue_request(zoll_pkg::CMD_INSERT, 42, 85, -86);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 50 == 0)
            begin
                gaps_on = (i < RANDOM_REQUESTS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            end
            if (i == 250 || i == 500)
            begin
                req_ch.valid <= 1'b0;
                do @(posedge clk); while (outstanding != 0);
            end
            r = $urandom_range(0, 99);
            if (filled < ID_COUNT && r < 30)
            begin
                id = ID_W'($urandom);
                while (placed[id])
                begin
                    id++;
                end
                decl = ($urandom_range(0, 2) == 0) ? DECL_W'($urandom)
                                                   : DECL_W'($urandom_range(0, filled + 1));
                issue_request(zoll_pkg::CMD_INSERT, id, decl, $signed(DELTA_W'($urandom)));
            end
            else if (r < 78)
            begin
                id = ID_W'($urandom);
                while (!placed[id])
                begin
                    id++;
                end
                d = ($urandom_range(0, 3) == 0) ? $signed(DELTA_W'($urandom))
                                                : $signed(DELTA_W'($urandom_range(0, 16) - 8));
                issue_request(zoll_pkg::CMD_MOVE, id, DECL_W'($urandom), d);
            end
            else if (r < 90)
            begin
                issue_request(zoll_pkg::CMD_INSERT, ID_W'($urandom), DECL_W'($urandom),
                              $signed(DELTA_W'($urandom)));
            end
            else
            begin
                issue_request(zoll_pkg::CMD_MOVE, ID_W'($urandom), DECL_W'($urandom),
                              $signed(DELTA_W'($urandom)));
            end
        end

        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (20) @(posedge clk);
        $display("Sent %0d requests (%0d inserts, %0d moves) and checked %0d results.",
                 inserts_sent + moves_sent, inserts_sent, moves_sent, checked);
        $display("The order filled %0d of %0d sprite slots under random stalls on both sides.",
                 filled, zoll_pkg::DEFAULT_MAX_SPRITES);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
design/zoll_pkg.sv
design/zoll_if.sv
design/zoll_ctrl.sv
design/zoll_datapath.sv
design/z_order_layer_list.sv
dv/zorder_checker.sv
dv/tb_z_order_layer_list.sv
